// ----- design/rpct_pkg.sv -----
// Package for range_paint_count_tree: item types and shared constants.
// No dependencies; used by range_paint_count_tree through scoped names.
package rpct_pkg;

	localparam int FIELD_W       = 11;
	localparam int MAX_POS_DFLT  = 1024;
	localparam int STACK_DEPTH   = 20;

	typedef struct packed {
		logic                 command;
		logic [FIELD_W-1:0]   range_start;
		logic [FIELD_W-1:0]   range_end;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_W-1:0]   white_total;
		logic                 range_error;
	} res_t;

endpackage

// ----- design/rpct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpct_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/rpct_bounds.sv -----
// Node bounds unit: position range [lo,hi] and size of one tree node,
// from the node index, the span exponent and the road length. No dependencies.
module rpct_bounds #(
	parameter int W  = 11,
	parameter int KW = 5
) (
	input  logic [W-1:0]  idx,
	input  logic [KW-1:0] k,
	input  logic [W-1:0]  len,
	output logic [W-1:0]  lo,
	output logic [W-1:0]  hi,
	output logic [W-1:0]  size
);

	localparam int XW = W + 2;

	logic [W:0]    n;
	logic [KW-1:0] d;
	logic [KW-1:0] sh;
	logic [XW-1:0] off;
	logic [XW-1:0] l;
	logic [XW-1:0] h;
	logic          deep;

	always_comb begin
		n = (W+1)'(idx) + (W+1)'(1);
		d = '0;
		for (int i = 0; i <= W; i++) begin
			if (n[i]) begin
				d = KW'(i);
			end
		end
		off  = XW'(n) - (XW'(1) << d);
		deep = d > k;
		sh   = deep ? '0 : k - d;
		l    = XW'(1) + (off << sh);
		// a node below the span has zero width: leave it empty
		h    = deep ? l - XW'(1) : l + (XW'(1) << sh) - XW'(1);
		if (h > XW'(len)) begin
			h = XW'(len);
		end
		lo   = W'(l);
		hi   = W'(h);
		size = (h >= l) ? W'(h - l + XW'(1)) : '0;
	end

endmodule

// ----- design/range_paint_count_tree.sv -----
// Range paint with white count, segment tree in one RAM walked by a sequencer.
// Each item walks the tree from a stack: pruned nodes are popped and checked, split
// nodes also push their children, an update rewrites each ancestor; an ignored item only reports.
// Throughput is set by the single RAM port pair and the one shared bounds unit.
// After reset or any road_length write a clearing pass sweeps the RAM
// (2048 entries by default); no item is taken meanwhile.
module range_paint_count_tree #(
	parameter int MAX_POSITIONS = rpct_pkg::MAX_POS_DFLT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  rpct_pkg::cmd_t                 cmd,
	output logic                           res_valid,
	input  logic                           res_stall,
	output rpct_pkg::res_t                 res,
	input  logic                           cfg_we,
	input  logic [rpct_pkg::FIELD_W-1:0]   cfg_wdata
);

	localparam int LG     = $clog2(MAX_POSITIONS);
	localparam int W      = LG + 1;
	localparam int KW     = $clog2(W + 1) + 1;
	localparam int FW     = rpct_pkg::FIELD_W;
	localparam int CW     = (W > FW) ? W : FW;
	localparam int DW     = W + 2;
	localparam int DEPTH  = 2 ** W;
	localparam int SD     = rpct_pkg::STACK_DEPTH;
	localparam int SPW    = $clog2(SD + 1);
	localparam int SI     = $clog2(SD);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_POP, ST_NODE, ST_CHL, ST_CHR, ST_UPWR, ST_FIN
	} state_t;

	state_t          state_q;
	logic [SPW-1:0]  sp_q;
	logic [W-1:0]    road_len_q;
	logic [KW-1:0]   k_q;
	logic [W-1:0]    clr_q;
	logic [W-1:0]    root_q;
	logic            res_valid_q;

	logic [W-1:0]    stk_q [SD];
	logic            white_q, err_q, aw_q, ab_q;
	logic [W-1:0]    a_q, b_q, qa_q, qb_q, idx_q, cur_q, delta_q, llo_q, lhi_q;
	rpct_pkg::res_t  res_q;

	// bounds unit and RAM
	logic [W-1:0]    b_idx, b_lo, b_hi, b_size;
	logic            we;
	logic [W-1:0]    waddr, raddr;
	logic [DW-1:0]   wdata, rdata;
	logic            rd_aw, rd_ab;
	logic [W-1:0]    rd_cnt;

	logic [W-1:0]    lch, rch, stk_top, qa, qb, now, up_cnt;
	logic            skip, exact, push_r, push_l, accept, invalid, load;
	logic [SPW-1:0]  sp1;
	logic [CW-1:0]   a_c, b_c, rl_c, v_c;
	logic [W-1:0]    vc;
	logic [KW-1:0]   kc;

	function automatic logic [W-1:0] parent(input logic [W-1:0] i);
		return (i - W'(1)) >> 1;
	endfunction

	rpct_bounds #(.W(W), .KW(KW)) u_bounds (
		.idx  (b_idx),
		.k    (k_q),
		.len  (road_len_q),
		.lo   (b_lo),
		.hi   (b_hi),
		.size (b_size)
	);

	rpct_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_aw   = rdata[W+1];
	assign rd_ab   = rdata[W];
	assign rd_cnt  = rdata[W-1:0];
	assign lch     = W'({idx_q, 1'b0} + (W+1)'(1));
	assign rch     = W'({idx_q, 1'b0} + (W+1)'(2));
	assign stk_top = stk_q[SI'(sp_q - SPW'(1))];
	assign up_cnt  = rd_cnt + delta_q;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign load      = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_comb begin
		a_c     = CW'(cmd.range_start);
		b_c     = CW'(cmd.range_end);
		rl_c    = CW'(road_len_q);
		invalid = (a_c == '0) || (b_c > rl_c) || (a_c > b_c);
	end

	// clamp the written road length and find the span exponent
	always_comb begin
		v_c = CW'(cfg_wdata);
		if (v_c == '0) begin
			v_c = CW'(1);
		end else if (v_c > CW'(MAX_POSITIONS)) begin
			v_c = CW'(MAX_POSITIONS);
		end
		vc = W'(v_c);
		kc = KW'(LG);
		for (int i = LG; i >= 0; i--) begin
			if (((CW+1)'(1) << i) >= (CW+1)'(v_c)) begin
				kc = KW'(i);
			end
		end
	end

	always_comb begin
		case (state_q)
			ST_CHL:  b_idx = lch;
			ST_CHR:  b_idx = rch;
			default: b_idx = idx_q;
		endcase
		qa     = (a_q > b_lo) ? a_q : b_lo;
		qb     = (b_q < b_hi) ? b_q : b_hi;
		skip   = (qa > qb) || (white_q && rd_aw) || (!white_q && rd_ab);
		exact  = (qa == b_lo) && (qb == b_hi);
		now    = white_q ? b_size : '0;
		push_r = (qb_q >= b_lo) && (sp_q < SPW'(SD));
		sp1    = sp_q + SPW'(push_r);
		push_l = (qa_q <= lhi_q) && (lhi_q >= llo_q) && (sp1 < SPW'(SD));
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		raddr = stk_top;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == '0) ? {1'b0, 1'b1, W'(0)} : '0;
			end
			ST_NODE: begin
				raddr = parent(idx_q);
				if (!skip) begin
					we    = 1'b1;
					// a split node loses its mark, an exact one takes the new color
					wdata = exact ? {white_q, !white_q, now} : {2'b00, rd_cnt};
				end
			end
			ST_CHL: begin
				we    = aw_q || ab_q;
				waddr = lch;
				wdata = aw_q ? {1'b1, 1'b0, b_size} : {1'b0, 1'b1, W'(0)};
			end
			ST_CHR: begin
				we    = aw_q || ab_q;
				waddr = rch;
				wdata = aw_q ? {1'b1, 1'b0, b_size} : {1'b0, 1'b1, W'(0)};
			end
			ST_UPWR: begin
				we    = 1'b1;
				waddr = cur_q;
				wdata = {rd_aw, rd_ab, up_cnt};
				raddr = parent(cur_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sp_q        <= '0;
			road_len_q  <= W'(MAX_POSITIONS);
			k_q         <= KW'(LG);
			clr_q       <= '0;
			root_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				road_len_q <= vc;
				k_q        <= kc;
				clr_q      <= '0;
				root_q     <= '0;
				state_q    <= ST_CLEAR;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + W'(1);
						if (clr_q == W'(DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							sp_q    <= SPW'(1);
							state_q <= invalid ? ST_FIN : ST_POP;
						end
					end
					ST_POP: begin
						if (sp_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							sp_q    <= sp_q - SPW'(1);
							state_q <= ST_NODE;
						end
					end
					ST_NODE: begin
						if (skip) begin
							state_q <= ST_POP;
						end else if (exact) begin
							if (idx_q == '0) begin
								root_q  <= now;
								state_q <= ST_POP;
							end else begin
								state_q <= ST_UPWR;
							end
						end else begin
							state_q <= ST_CHL;
						end
					end
					ST_CHL: begin
						state_q <= ST_CHR;
					end
					ST_CHR: begin
						sp_q    <= sp1 + SPW'(push_l);
						state_q <= ST_POP;
					end
					ST_UPWR: begin
						if (cur_q == '0) begin
							root_q  <= up_cnt;
							state_q <= ST_POP;
						end
					end
					ST_FIN: begin
						if (load) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					white_q  <= cmd.command;
					a_q      <= W'(a_c);
					b_q      <= W'(b_c);
					err_q    <= invalid;
					stk_q[0] <= '0;
				end
			end
			ST_POP: begin
				idx_q <= stk_top;
			end
			ST_NODE: begin
				aw_q    <= rd_aw;
				ab_q    <= rd_ab;
				qa_q    <= qa;
				qb_q    <= qb;
				delta_q <= now - rd_cnt;
				cur_q   <= parent(idx_q);
			end
			ST_CHL: begin
				llo_q <= b_lo;
				lhi_q <= b_hi;
			end
			ST_CHR: begin
				// right first so the left child is walked next
				if (push_r) begin
					stk_q[SI'(sp_q)] <= rch;
				end
				if (push_l) begin
					stk_q[SI'(sp1)] <= lch;
				end
			end
			ST_UPWR: begin
				cur_q <= parent(cur_q);
			end
			ST_FIN: begin
				if (load) begin
					res_q.white_total <= FW'(root_q);
					res_q.range_error <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(SD))
		else $error("walk stack pointer past its depth");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		root_q <= road_len_q)
		else $error("white count above road length");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("item taken while previous one still in work");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == ST_CLEAR) && (root_q == '0))
		else $error("road length write did not start clearing pass");

endmodule
